FILE: hdl/scd_pkg.sv
// Shared types and constants of the task scheduler with semaphores.
// No dependencies; scd_cfg, scd_task_mem, the top level and scd_checker use it by scoped names.
package scd_pkg;

    localparam int TASK_SLOTS_DEF      = 16;
    localparam int QUEUE_DEPTH_DEF     = 16;
    localparam int SEMAPHORE_COUNT_DEF = 4;

    localparam int CFG_REGS = 4;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;
    localparam int COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // command codes
    localparam logic [2:0] ACT_SCHEDULE = 3'd0;
    localparam logic [2:0] ACT_TICK     = 3'd1;
    localparam logic [2:0] ACT_CREATE   = 3'd2;
    localparam logic [2:0] ACT_DESTROY  = 3'd3;
    localparam logic [2:0] ACT_SLEEP    = 3'd4;
    localparam logic [2:0] ACT_WAIT     = 3'd5;
    localparam logic [2:0] ACT_POST     = 3'd6;
    localparam logic [2:0] ACT_KRESET   = 3'd7;

    // task states
    localparam logic [1:0] TS_FREE    = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_BLOCKED = 2'd2;
    localparam logic [1:0] TS_DELAYED = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BLOCKED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_NOREADY  = 3'd5;
    localparam logic [2:0] ST_QFULL    = 3'd6;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] id;
        logic [2:0]  level;
        logic [2:0]  skip;
        logic [31:0] sleep;
        logic [1:0]  wsem;
    } task_entry_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_T_RD  = 8'b0000_0010,
        S_T_EX  = 8'b0000_0100,
        S_QH_RD = 8'b0000_1000,
        S_QH_EX = 8'b0001_0000,
        S_Q_RD  = 8'b0010_0000,
        S_Q_EX  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } fsm_t;

endpackage

FILE: hdl/scd_channels.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing; used by the top level and the testbench.
interface scd_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] process_id;
    logic [2:0]  priority_req;
    logic [1:0]  semaphore;
    logic [31:0] tick_count;

    modport source (output valid, action, process_id, priority_req, semaphore, tick_count,
                    input ready);
    modport sink (input valid, action, process_id, priority_req, semaphore, tick_count,
                  output ready);
endinterface

interface scd_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] task_slot;
    logic       woke_valid;
    logic [3:0] woke_slot;

    modport source (output valid, status, task_slot, woke_valid, woke_slot, input ready);
    modport sink (input valid, status, task_slot, woke_valid, woke_slot, output ready);
endinterface

FILE: hdl/scd_cfg.sv
// APB-style register file holding the initial semaphore counts.
// Depends on scd_pkg.
module scd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scd_pkg::CFG_AW-1:0]    paddr,
    input  logic [scd_pkg::CFG_DW-1:0]    pwdata,
    output logic [scd_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready,
    output logic [scd_pkg::COUNT_W-1:0]   init_count [scd_pkg::CFG_REGS]
);

    logic [scd_pkg::COUNT_W-1:0] init_reg [scd_pkg::CFG_REGS];
    logic [1:0]                  sel;

    assign sel    = paddr[3:2];
    assign pready = 1'b1;
    assign prdata = scd_pkg::CFG_DW'(init_reg[sel]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scd_pkg::CFG_REGS; i++)
            begin
                init_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            init_reg[sel] <= pwdata[scd_pkg::COUNT_W-1:0];
        end
    end

    assign init_count = init_reg;

endmodule

FILE: hdl/scd_task_mem.sv
// Task table memory: one entry per slot, registered read, valid bits so that
// a kernel reset clears the table at once. Depends on scd_pkg.
module scd_task_mem #(
    parameter int TASK_SLOTS = scd_pkg::TASK_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic [$clog2(TASK_SLOTS)-1:0] raddr,
    output scd_pkg::task_entry_t        rdata,
    input  logic                        we,
    input  logic [$clog2(TASK_SLOTS)-1:0] waddr,
    input  scd_pkg::task_entry_t        wdata
);

    scd_pkg::task_entry_t   mem [TASK_SLOTS];
    scd_pkg::task_entry_t   data_reg;
    logic [TASK_SLOTS-1:0]  valid_reg;
    logic                   rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[raddr];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // entries never written since the last clear read as all zero
    assign rdata = rvalid_reg ? data_reg : '0;

endmodule

FILE: hdl/scd_queue_mem.sv
// Wait queue memory holding slot numbers for all semaphores, registered read.
// Depends on nothing.
module scd_queue_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 4
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

FILE: hdl/task_scheduler_with_semaphores.sv
// Round-robin task scheduler with counting semaphores, the sequencer on top.
// Depends on scd_pkg, scd_channels, scd_cfg, scd_task_mem and scd_queue_mem.
//
// Usage: one request on cmd carries one command; exactly one result follows
// on res. Configuration (initial semaphore counts) is written over the APB
// port while the block is idle. One request is worked at a time; cmd.ready
// is high only while the sequencer waits for work. Kernel reset, post to an
// empty queue, an out-of-range semaphore and create on a full table finish
// without a table visit; sleep and wait visit the running task's slot; tick
// and create visit every slot; destroy walks to the hit slot, then through
// the queue of a blocked task; post with waiters reads the queue head,
// visits that slot and walks its queue; schedule walks until a task is
// chosen, passing over each ready task up to 7 times. Every slot visit is a
// read of the task table memory with a write-back where the entry changes,
// and every queue step a read of the queue memory with a write where an
// entry moves. A finished result sits in an output register, so the next
// request is taken while it waits; the sequencer holds only when a second
// result is ready before the first is taken. Reset clears the task table
// valid bits, counts and queue lengths at once; no clearing pass is needed.
module task_scheduler_with_semaphores #(
    parameter int TASK_SLOTS      = scd_pkg::TASK_SLOTS_DEF,
    parameter int QUEUE_DEPTH     = scd_pkg::QUEUE_DEPTH_DEF,
    parameter int SEMAPHORE_COUNT = scd_pkg::SEMAPHORE_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    scd_cmd_if.sink                    cmd,
    scd_res_if.source                  res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [scd_pkg::CFG_AW-1:0] paddr,
    input  logic [scd_pkg::CFG_DW-1:0] pwdata,
    output logic [scd_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    localparam int SW  = $clog2(TASK_SLOTS);
    localparam int SCW = $clog2(TASK_SLOTS + 1);
    localparam int QIW = $clog2(QUEUE_DEPTH);
    localparam int QLW = $clog2(QUEUE_DEPTH + 1);
    localparam int QAD = SEMAPHORE_COUNT * QUEUE_DEPTH;
    localparam int QAW = $clog2(QAD);
    localparam int SIW = (SEMAPHORE_COUNT > 1) ? $clog2(SEMAPHORE_COUNT) : 1;
    localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);
    localparam int CW = scd_pkg::COUNT_W;

    logic [CW-1:0] init_count [scd_pkg::CFG_REGS];

    scd_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .init_count (init_count)
    );

    // task table and queue memories
    scd_pkg::task_entry_t tm_rdata;
    scd_pkg::task_entry_t tm_wdata;
    logic                 tm_we;
    logic [SW-1:0]        tm_waddr;
    logic                 kclear;

    logic [QAW-1:0]       qm_raddr;
    logic [QAW-1:0]       qm_waddr;
    logic [SW-1:0]        qm_rdata;
    logic [SW-1:0]        qm_wdata;
    logic                 qm_we;

    // sequencer registers
    scd_pkg::fsm_t  state_reg, state_next;
    logic [2:0]     op_reg, op_next;
    logic [31:0]    pid_reg, pid_next;
    logic [2:0]     prio_reg, prio_next;
    logic [1:0]     sem_reg, sem_next;
    logic [31:0]    ticks_reg, ticks_next;
    logic [SW-1:0]  idx_reg, idx_next;
    logic [SCW-1:0] steps_reg, steps_next;
    logic           seen_reg, seen_next;
    logic           dup_reg, dup_next;
    logic           free_ok_reg, free_ok_next;
    logic [SW-1:0]  free_reg, free_next;
    logic [QIW-1:0] qj_reg, qj_next;
    logic [QLW-1:0] qn_reg, qn_next;
    logic [SW-1:0]  qslot_reg, qslot_next;
    logic [SIW-1:0] qsem_reg, qsem_next;
    logic           qfound_reg, qfound_next;
    logic [2:0]     st_reg, st_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic           wv_reg, wv_next;
    logic [SW-1:0]  ws_reg, ws_next;

    // kernel state kept in flops
    logic [SW-1:0]  scan_reg, scan_next;
    logic [SW-1:0]  run_reg, run_next;
    logic [SCW-1:0] live_reg, live_next;
    logic [CW-1:0]  semcnt_reg [SEMAPHORE_COUNT];
    logic [CW-1:0]  semcnt_next [SEMAPHORE_COUNT];
    logic [QLW-1:0] qlen_reg [SEMAPHORE_COUNT];
    logic [QLW-1:0] qlen_next [SEMAPHORE_COUNT];

    // output register
    logic           ov_reg, ov_next;
    logic [2:0]     ost_reg, ost_next;
    logic [3:0]     oslot_reg, oslot_next;
    logic           owv_reg, owv_next;
    logic [3:0]     ows_reg, ows_next;

    logic [SIW-1:0] semi;

    function automatic logic [QAW-1:0] qaddr(input logic [SIW-1:0] s,
                                             input logic [QIW-1:0] j);
        return QAW'(s) * QAW'(QUEUE_DEPTH) + QAW'(j);
    endfunction

    scd_task_mem #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_task_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (kclear),
        .raddr (idx_reg),
        .rdata (tm_rdata),
        .we    (tm_we),
        .waddr (tm_waddr),
        .wdata (tm_wdata)
    );

    scd_queue_mem #(
        .DEPTH (QAD),
        .WIDTH (SW)
    ) u_queue_mem (
        .clk   (clk),
        .raddr (qm_raddr),
        .rdata (qm_rdata),
        .we    (qm_we),
        .waddr (qm_waddr),
        .wdata (qm_wdata)
    );

    assign semi      = SIW'(sem_reg);
    assign qm_raddr  = qaddr(qsem_reg, qj_reg);
    assign cmd.ready = (state_reg == scd_pkg::S_IDLE);

    assign res.valid      = ov_reg;
    assign res.status     = ost_reg;
    assign res.task_slot  = oslot_reg;
    assign res.woke_valid = owv_reg;
    assign res.woke_slot  = ows_reg;

    always_comb
    begin
        scd_pkg::task_entry_t e;
        scd_pkg::task_entry_t w;
        logic                 chosen;
        logic                 seen_n;
        logic                 dup_n;
        logic                 free_ok_n;
        logic [SW-1:0]        free_n;
        logic                 found_n;
        logic [SIW-1:0]       rs;
        logic [SIW-1:0]       in_semi;
        logic                 in_sem_bad;

        state_next   = state_reg;
        op_next      = op_reg;
        pid_next     = pid_reg;
        prio_next    = prio_reg;
        sem_next     = sem_reg;
        ticks_next   = ticks_reg;
        idx_next     = idx_reg;
        steps_next   = steps_reg;
        seen_next    = seen_reg;
        dup_next     = dup_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        qj_next      = qj_reg;
        qn_next      = qn_reg;
        qslot_next   = qslot_reg;
        qsem_next    = qsem_reg;
        qfound_next  = qfound_reg;
        st_next      = st_reg;
        slot_next    = slot_reg;
        wv_next      = wv_reg;
        ws_next      = ws_reg;
        scan_next    = scan_reg;
        run_next     = run_reg;
        live_next    = live_reg;
        semcnt_next  = semcnt_reg;
        qlen_next    = qlen_reg;

        ov_next    = ov_reg && !res.ready;
        ost_next   = ost_reg;
        oslot_next = oslot_reg;
        owv_next   = owv_reg;
        ows_next   = ows_reg;

        tm_we    = 1'b0;
        tm_waddr = idx_reg;
        tm_wdata = tm_rdata;
        qm_we    = 1'b0;
        qm_waddr = qaddr(qsem_reg, qj_reg);
        qm_wdata = qm_rdata;
        kclear   = 1'b0;

        e          = tm_rdata;
        w          = tm_rdata;
        chosen     = 1'b0;
        seen_n     = seen_reg;
        dup_n      = dup_reg;
        free_ok_n  = free_ok_reg;
        free_n     = free_reg;
        found_n    = qfound_reg;
        rs         = SIW'(e.wsem);
        in_semi    = SIW'(cmd.semaphore);
        in_sem_bad = (32'(cmd.semaphore) >= 32'(SEMAPHORE_COUNT));

        case (state_reg)
            scd_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.action;
                    pid_next   = cmd.process_id;
                    prio_next  = cmd.priority_req;
                    sem_next   = cmd.semaphore;
                    ticks_next = cmd.tick_count;
                    st_next    = scd_pkg::ST_OK;
                    slot_next  = '0;
                    wv_next    = 1'b0;
                    ws_next    = '0;
                    idx_next   = '0;
                    steps_next = '0;
                    seen_next  = 1'b0;
                    dup_next   = 1'b0;
                    free_ok_next = 1'b0;
                    state_next = scd_pkg::S_T_RD;
                    case (cmd.action)
                        scd_pkg::ACT_SCHEDULE:
                        begin
                            idx_next = (scan_reg == LAST) ? '0 : scan_reg + 1'b1;
                        end
                        scd_pkg::ACT_CREATE:
                        begin
                            if (live_reg >= SCW'(TASK_SLOTS))
                            begin
                                st_next    = scd_pkg::ST_FULL;
                                state_next = scd_pkg::S_DONE;
                            end
                        end
                        scd_pkg::ACT_SLEEP:
                        begin
                            idx_next = run_reg;
                        end
                        scd_pkg::ACT_WAIT:
                        begin
                            idx_next = run_reg;
                            if (in_sem_bad)
                            begin
                                st_next    = scd_pkg::ST_NOTFOUND;
                                state_next = scd_pkg::S_DONE;
                            end
                        end
                        scd_pkg::ACT_POST:
                        begin
                            qsem_next = in_semi;
                            qj_next   = '0;
                            if (in_sem_bad)
                            begin
                                st_next    = scd_pkg::ST_NOTFOUND;
                                state_next = scd_pkg::S_DONE;
                            end
                            else if (qlen_reg[in_semi] != '0)
                            begin
                                state_next = scd_pkg::S_QH_RD;
                            end
                            else
                            begin
                                if (semcnt_reg[in_semi] != scd_pkg::COUNT_MAX)
                                begin
                                    semcnt_next[in_semi] = semcnt_reg[in_semi] + 1'b1;
                                end
                                state_next = scd_pkg::S_DONE;
                            end
                        end
                        scd_pkg::ACT_KRESET:
                        begin
                            kclear = 1'b1;
                            for (int s = 0; s < SEMAPHORE_COUNT; s++)
                            begin
                                if (s < scd_pkg::CFG_REGS)
                                begin
                                    semcnt_next[s] = init_count[s[1:0]];
                                end
                                else
                                begin
                                    semcnt_next[s] = '0;
                                end
                                qlen_next[s] = '0;
                            end
                            scan_next  = LAST;
                            run_next   = '0;
                            live_next  = '0;
                            state_next = scd_pkg::S_DONE;
                        end
                        default:
                        begin
                            // tick and destroy walk from slot zero
                        end
                    endcase
                end
            end

            scd_pkg::S_T_RD:
            begin
                state_next = scd_pkg::S_T_EX;
            end

            scd_pkg::S_T_EX:
            begin
                case (op_reg)
                    scd_pkg::ACT_SCHEDULE:
                    begin
                        if (e.state == scd_pkg::TS_READY)
                        begin
                            seen_n   = 1'b1;
                            tm_we    = 1'b1;
                            if (e.skip == '0)
                            begin
                                w.skip     = e.level;
                                scan_next  = idx_reg;
                                run_next   = idx_reg;
                                slot_next  = idx_reg;
                                chosen     = 1'b1;
                                state_next = scd_pkg::S_DONE;
                            end
                            else
                            begin
                                w.skip = e.skip - 1'b1;
                            end
                            tm_wdata = w;
                        end
                        seen_next = seen_n;
                        if (!chosen)
                        begin
                            idx_next   = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                            state_next = scd_pkg::S_T_RD;
                            if (!seen_n)
                            begin
                                steps_next = steps_reg + 1'b1;
                                // a full lap with no ready task
                                if ((steps_reg + 1'b1) == SCW'(TASK_SLOTS))
                                begin
                                    st_next    = scd_pkg::ST_NOREADY;
                                    state_next = scd_pkg::S_DONE;
                                end
                            end
                        end
                    end

                    scd_pkg::ACT_TICK:
                    begin
                        if (e.state == scd_pkg::TS_DELAYED)
                        begin
                            if (e.sleep != '0)
                            begin
                                w.sleep = e.sleep - 1'b1;
                            end
                            if (w.sleep == '0)
                            begin
                                w.state = scd_pkg::TS_READY;
                            end
                            tm_we    = 1'b1;
                            tm_wdata = w;
                        end
                        idx_next   = idx_reg + 1'b1;
                        state_next = (idx_reg == LAST) ? scd_pkg::S_DONE : scd_pkg::S_T_RD;
                    end

                    scd_pkg::ACT_CREATE:
                    begin
                        if (e.state != scd_pkg::TS_FREE && e.id == pid_reg)
                        begin
                            dup_n = 1'b1;
                        end
                        if (!free_ok_reg && e.state == scd_pkg::TS_FREE)
                        begin
                            free_ok_n = 1'b1;
                            free_n    = idx_reg;
                        end
                        dup_next     = dup_n;
                        free_ok_next = free_ok_n;
                        free_next    = free_n;
                        idx_next     = idx_reg + 1'b1;
                        state_next   = scd_pkg::S_T_RD;
                        if (idx_reg == LAST)
                        begin
                            state_next = scd_pkg::S_DONE;
                            if (dup_n)
                            begin
                                st_next = scd_pkg::ST_DUP;
                            end
                            else if (!free_ok_n)
                            begin
                                st_next = scd_pkg::ST_FULL;
                            end
                            else
                            begin
                                w.state  = scd_pkg::TS_READY;
                                w.id     = pid_reg;
                                w.level  = prio_reg;
                                w.skip   = prio_reg;
                                w.sleep  = '0;
                                w.wsem   = '0;
                                tm_we    = 1'b1;
                                tm_waddr = free_n;
                                tm_wdata = w;
                                live_next = live_reg + 1'b1;
                                slot_next = free_n;
                            end
                        end
                    end

                    scd_pkg::ACT_DESTROY:
                    begin
                        if (e.state != scd_pkg::TS_FREE && e.id == pid_reg)
                        begin
                            w.state  = scd_pkg::TS_FREE;
                            w.id     = '0;
                            w.sleep  = '0;
                            tm_we    = 1'b1;
                            tm_wdata = w;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                            state_next = scd_pkg::S_DONE;
                            if (e.state == scd_pkg::TS_BLOCKED &&
                                32'(e.wsem) < 32'(SEMAPHORE_COUNT))
                            begin
                                qsem_next   = rs;
                                qslot_next  = idx_reg;
                                qn_next     = qlen_reg[rs];
                                qj_next     = '0;
                                qfound_next = 1'b0;
                                if (qlen_reg[rs] != '0)
                                begin
                                    state_next = scd_pkg::S_Q_RD;
                                end
                            end
                        end
                        else if (idx_reg == LAST)
                        begin
                            st_next    = scd_pkg::ST_NOTFOUND;
                            state_next = scd_pkg::S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = scd_pkg::S_T_RD;
                        end
                    end

                    scd_pkg::ACT_SLEEP:
                    begin
                        state_next = scd_pkg::S_DONE;
                        if (e.state != scd_pkg::TS_READY)
                        begin
                            st_next = scd_pkg::ST_NOTFOUND;
                        end
                        else if (ticks_reg != '0)
                        begin
                            w.state  = scd_pkg::TS_DELAYED;
                            w.sleep  = ticks_reg;
                            tm_we    = 1'b1;
                            tm_wdata = w;
                            st_next  = scd_pkg::ST_BLOCKED;
                        end
                    end

                    scd_pkg::ACT_WAIT:
                    begin
                        state_next = scd_pkg::S_DONE;
                        if (e.state != scd_pkg::TS_READY)
                        begin
                            st_next = scd_pkg::ST_NOTFOUND;
                        end
                        else if (semcnt_reg[semi] != '0)
                        begin
                            semcnt_next[semi] = semcnt_reg[semi] - 1'b1;
                        end
                        else if (qlen_reg[semi] >= QLW'(QUEUE_DEPTH))
                        begin
                            st_next = scd_pkg::ST_QFULL;
                        end
                        else
                        begin
                            // append the running task at the tail
                            qm_we           = 1'b1;
                            qm_waddr        = qaddr(semi, QIW'(qlen_reg[semi]));
                            qm_wdata        = run_reg;
                            qlen_next[semi] = qlen_reg[semi] + 1'b1;
                            w.state         = scd_pkg::TS_BLOCKED;
                            w.wsem          = sem_reg;
                            tm_we           = 1'b1;
                            tm_wdata        = w;
                            st_next         = scd_pkg::ST_BLOCKED;
                        end
                    end

                    scd_pkg::ACT_POST:
                    begin
                        if (e.state == scd_pkg::TS_BLOCKED)
                        begin
                            w.state  = scd_pkg::TS_READY;
                            tm_we    = 1'b1;
                            tm_wdata = w;
                        end
                        wv_next     = 1'b1;
                        ws_next     = idx_reg;
                        qsem_next   = semi;
                        qslot_next  = idx_reg;
                        qn_next     = qlen_reg[semi];
                        qj_next     = '0;
                        qfound_next = 1'b0;
                        state_next  = scd_pkg::S_Q_RD;
                    end

                    default:
                    begin
                        state_next = scd_pkg::S_DONE;
                    end
                endcase
            end

            scd_pkg::S_QH_RD:
            begin
                state_next = scd_pkg::S_QH_EX;
            end

            scd_pkg::S_QH_EX:
            begin
                idx_next   = qm_rdata;
                state_next = scd_pkg::S_T_RD;
            end

            scd_pkg::S_Q_RD:
            begin
                state_next = scd_pkg::S_Q_EX;
            end

            scd_pkg::S_Q_EX:
            begin
                // move each entry after the match up by one
                if (qfound_reg)
                begin
                    qm_we    = 1'b1;
                    qm_waddr = qaddr(qsem_reg, qj_reg - 1'b1);
                    qm_wdata = qm_rdata;
                end
                else if (qm_rdata == qslot_reg)
                begin
                    found_n = 1'b1;
                end
                qfound_next = found_n;
                if (QLW'(qj_reg) == qn_reg - 1'b1)
                begin
                    if (found_n)
                    begin
                        qlen_next[qsem_reg] = qn_reg - 1'b1;
                    end
                    state_next = scd_pkg::S_DONE;
                end
                else
                begin
                    qj_next    = qj_reg + 1'b1;
                    state_next = scd_pkg::S_Q_RD;
                end
            end

            scd_pkg::S_DONE:
            begin
                if (!ov_reg || res.ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    oslot_next = 4'(slot_reg);
                    owv_next   = wv_reg;
                    ows_next   = 4'(ws_reg);
                    state_next = scd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = scd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scd_pkg::S_IDLE;
            ov_reg    <= 1'b0;
            scan_reg  <= LAST;
            run_reg   <= '0;
            live_reg  <= '0;
            for (int s = 0; s < SEMAPHORE_COUNT; s++)
            begin
                semcnt_reg[s] <= '0;
                qlen_reg[s]   <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            scan_reg   <= scan_next;
            run_reg    <= run_next;
            live_reg   <= live_next;
            semcnt_reg <= semcnt_next;
            qlen_reg   <= qlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pid_reg     <= pid_next;
        prio_reg    <= prio_next;
        sem_reg     <= sem_next;
        ticks_reg   <= ticks_next;
        idx_reg     <= idx_next;
        steps_reg   <= steps_next;
        seen_reg    <= seen_next;
        dup_reg     <= dup_next;
        free_ok_reg <= free_ok_next;
        free_reg    <= free_next;
        qj_reg      <= qj_next;
        qn_reg      <= qn_next;
        qslot_reg   <= qslot_next;
        qsem_reg    <= qsem_next;
        qfound_reg  <= qfound_next;
        st_reg      <= st_next;
        slot_reg    <= slot_next;
        wv_reg      <= wv_next;
        ws_reg      <= ws_next;
        ost_reg     <= ost_next;
        oslot_reg   <= oslot_next;
        owv_reg     <= owv_next;
        ows_reg     <= ows_next;
    end

endmodule

FILE: hdl/scd_checker.sv
// Port-level checks on the scheduler's result channel, bound to the top.
// Depends on scd_pkg and task_scheduler_with_semaphores.
module scd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] status,
    input logic       woke_valid,
    input logic [3:0] woke_slot
);

    // hold a result until it is taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status != 3'd7)
        else $error("undefined status code");

    // only a successful post wakes a task
    a_woke_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && woke_valid |-> status == scd_pkg::ST_OK)
        else $error("wake reported with an error status");

    a_woke_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !woke_valid |-> woke_slot == 4'd0)
        else $error("woken slot set without a wake");

endmodule

bind task_scheduler_with_semaphores scd_checker u_scd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .status     (res.status),
    .woke_valid (res.woke_valid),
    .woke_slot  (res.woke_slot)
);

FILE: dv/scd_scoreboard.sv
`timescale 1ns / 100ps
// Scheduler state predictor and result checker for the task scheduler test.
// Depends on scd_pkg for command, state and status codes.
package scd_scoreboard_pkg;
    import scd_pkg::*;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] process_id;
        logic [2:0]  priority_req;
        logic [1:0]  semaphore;
        logic [31:0] tick_count;
    } sched_cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] task_slot;
        logic       woke_valid;
        logic [3:0] woke_slot;
    } sched_res_t;

    class sched_scoreboard;
        localparam int NT = 16;
        localparam int NQ = 16;
        localparam int NS = 4;

        logic [15:0] init_count [NS];
        logic [1:0]  tstate [NT];
        logic [31:0] tid [NT];
        logic [2:0]  tlevel [NT];
        logic [2:0]  tskip [NT];
        logic [31:0] tsleep [NT];
        logic [1:0]  twsem [NT];
        logic [15:0] sem_count [NS];
        logic [3:0]  wq [NS][NQ];
        int          qlen [NS];
        int          scan_pos;
        int          running;
        int          live;
        sched_res_t  pending [$];
        int          mismatches;
        int          checked;

        function new();
            foreach (init_count[i]) init_count[i] = '0;
            foreach (wq[s, j]) wq[s][j] = '0;
            mismatches = 0;
            checked = 0;
            clear_kernel();
        endfunction

        function void clear_kernel();
            foreach (tstate[i])
            begin
                tstate[i] = TS_FREE;
                tid[i] = '0;
                tlevel[i] = '0;
                tskip[i] = '0;
                tsleep[i] = '0;
                twsem[i] = '0;
            end
            foreach (sem_count[s])
            begin
                sem_count[s] = init_count[s];
                qlen[s] = 0;
            end
            scan_pos = NT - 1;
            running = 0;
            live = 0;
        endfunction

        function void dequeue_slot(int s, int slot);
            for (int j = 0; j < qlen[s]; j++)
            begin
                if (wq[s][j] == slot)
                begin
                    for (int k = j + 1; k < qlen[s]; k++)
                        wq[s][k-1] = wq[s][k];
                    qlen[s]--;
                    return;
                end
            end
        endfunction

        // Advance the kernel state by one request and queue its result.
        function void note_request(sched_cmd_t c);
            sched_res_t r;
            int cur;
            int pos;
            int hit;
            int s;
            bit any;
            r = '0;
            r.status = ST_OK;
            cur = running;
            s = c.semaphore;
            case (c.action)
                ACT_SCHEDULE:
                begin
                    any = 0;
                    foreach (tstate[i]) if (tstate[i] == TS_READY) any = 1;
                    if (!any)
                        r.status = ST_NOREADY;
                    else
                    begin
                        pos = scan_pos;
                        for (int g = 0; g < 9 * NT + 1; g++)
                        begin
                            pos = (pos + 1) % NT;
                            if (tstate[pos] != TS_READY) continue;
                            if (tskip[pos] == 0)
                            begin
                                tskip[pos] = tlevel[pos];
                                scan_pos = pos;
                                running = pos;
                                r.task_slot = pos;
                                break;
                            end
                            tskip[pos]--;
                        end
                    end
                end
                ACT_TICK:
                    foreach (tstate[i])
                        if (tstate[i] == TS_DELAYED)
                        begin
                            if (tsleep[i] > 0) tsleep[i]--;
                            if (tsleep[i] == 0) tstate[i] = TS_READY;
                        end
                ACT_CREATE:
                begin
                    hit = NT;
                    if (live >= NT)
                        r.status = ST_FULL;
                    else
                    begin
                        foreach (tstate[i])
                            if (tstate[i] != TS_FREE && tid[i] == c.process_id)
                                r.status = ST_DUP;
                        if (r.status == ST_OK)
                        begin
                            for (int i = NT - 1; i >= 0; i--)
                                if (tstate[i] == TS_FREE) hit = i;
                            if (hit == NT)
                                r.status = ST_FULL;
                            else
                            begin
                                tstate[hit] = TS_READY;
                                tid[hit] = c.process_id;
                                tlevel[hit] = c.priority_req;
                                tskip[hit] = c.priority_req;
                                tsleep[hit] = '0;
                                twsem[hit] = '0;
                                live++;
                                r.task_slot = hit;
                            end
                        end
                    end
                end
                ACT_DESTROY:
                begin
                    hit = NT;
                    for (int i = NT - 1; i >= 0; i--)
                        if (tstate[i] != TS_FREE && tid[i] == c.process_id) hit = i;
                    if (hit == NT)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        if (tstate[hit] == TS_BLOCKED) dequeue_slot(twsem[hit], hit);
                        tstate[hit] = TS_FREE;
                        tid[hit] = '0;
                        tsleep[hit] = '0;
                        if (live > 0) live--;
                    end
                end
                ACT_SLEEP:
                    if (tstate[cur] != TS_READY)
                        r.status = ST_NOTFOUND;
                    else if (c.tick_count != 0)
                    begin
                        tstate[cur] = TS_DELAYED;
                        tsleep[cur] = c.tick_count;
                        r.status = ST_BLOCKED;
                    end
                ACT_WAIT:
                    if (tstate[cur] != TS_READY)
                        r.status = ST_NOTFOUND;
                    else if (sem_count[s] > 0)
                        sem_count[s]--;
                    else if (qlen[s] >= NQ)
                        r.status = ST_QFULL;
                    else
                    begin
                        wq[s][qlen[s]] = cur;
                        qlen[s]++;
                        twsem[cur] = s;
                        tstate[cur] = TS_BLOCKED;
                        r.status = ST_BLOCKED;
                    end
                ACT_POST:
                    if (qlen[s] > 0)
                    begin
                        pos = wq[s][0];
                        if (tstate[pos] == TS_BLOCKED) tstate[pos] = TS_READY;
                        dequeue_slot(s, pos);
                        r.woke_valid = 1'b1;
                        r.woke_slot = pos;
                    end
                    else if (sem_count[s] != COUNT_MAX)
                        sem_count[s]++;
                default:
                    clear_kernel();
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(sched_res_t got);
            sched_res_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected %p, got %p", checked, want, got);
            end
        endfunction
    endclass
endpackage

FILE: dv/task_scheduler_with_semaphores_test.sv
`timescale 1ns / 100ps
// Top-level test of the task scheduler: directed and random commands with
// random idling on both channels. Depends on scd_pkg, scd_channels, the RTL
// and scd_scoreboard_pkg.
module task_scheduler_with_semaphores_test;
    import scd_pkg::*;
    import scd_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    scd_cmd_if cmd ();
    scd_res_if res ();

    task_scheduler_with_semaphores DUT (
        .clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .res(res.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sched_scoreboard board;
    bit   calm;
    int   cycles;
    int   sent;
    logic [31:0] pid_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("task_scheduler_with_semaphores_test: errors");
            $finish;
        end
    end

    // Result sink with random stall.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            board.check_result('{res.status, res.task_slot, res.woke_valid, res.woke_slot});
    end

    always @(negedge clk)
        res.ready <= calm || ($urandom_range(99) >= 14);

    task automatic write_count(int idx, logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= CFG_AW'(4 * idx);
        pwdata <= {16'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.init_count[idx] = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_request(sched_cmd_t c);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 14)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.action <= c.action;
        cmd.process_id <= c.process_id;
        cmd.priority_req <= c.priority_req;
        cmd.semaphore <= c.semaphore;
        cmd.tick_count <= c.tick_count;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        board.note_request(c);
        sent++;
        @(negedge clk);
        cmd.valid <= 1'b0;
    endtask

    task automatic issue(logic [2:0] a, logic [31:0] pid = 32'd1, logic [2:0] pr = 3'd0,
                         logic [1:0] sm = 2'd0, logic [31:0] tk = 32'd0);
        send_request('{a, pid, pr, sm, tk});
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic sched_cmd_t random_request();
        sched_cmd_t c;
        int pick;
        c.process_id = ($urandom_range(3) == 0) ? $urandom() : pid_pool[$urandom_range(7)];
        c.priority_req = $urandom_range(7);
        c.semaphore = $urandom_range(3);
        pick = $urandom_range(3);
        c.tick_count = (pick == 0) ? $urandom() : $urandom_range(4);
        pick = $urandom_range(99);
        if (pick < 25) c.action = ACT_SCHEDULE;
        else if (pick < 37) c.action = ACT_TICK;
        else if (pick < 52) c.action = ACT_CREATE;
        else if (pick < 60) c.action = ACT_DESTROY;
        else if (pick < 67) c.action = ACT_SLEEP;
        else if (pick < 80) c.action = ACT_WAIT;
        else if (pick < 98) c.action = ACT_POST;
        else c.action = ACT_KRESET;
        return c;
    endfunction

    initial
    begin
        board = new();
        cycles = 0;
        sent = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd.valid = 1'b0;
        cmd.action = ACT_SCHEDULE;
        cmd.process_id = '0;
        cmd.priority_req = '0;
        cmd.semaphore = '0;
        cmd.tick_count = '0;
        res.ready = 1'b0;
        pid_pool = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd7, 32'h1234_5678, 32'd2,
                     32'h5555_AAAA, 32'hAAAA_5555};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty schedule, full table, duplicates, sleeps, queues.
        issue(ACT_SCHEDULE);
        issue(ACT_WAIT, 1, 0, 0);
        issue(ACT_POST, 1, 0, 3);
        issue(ACT_KRESET);
        for (int i = 0; i < 16; i++)
            issue(ACT_CREATE, 32'h100 + i, i[2:0]);
        issue(ACT_CREATE, 32'hFFFF_FFFF, 3'd7);
        issue(ACT_DESTROY, 32'h100);
        issue(ACT_CREATE, 32'h101);
        issue(ACT_DESTROY, 32'hDEAD_BEEF);
        drain();

        write_count(0, 16'hFFFF);
        write_count(1, 16'd1);
        write_count(2, 16'd0);
        write_count(3, 16'h8000);
        issue(ACT_KRESET);
        issue(ACT_CREATE, 32'hFFFF_FFFF, 3'd7);
        issue(ACT_CREATE, 32'd1, 3'd0);
        issue(ACT_SCHEDULE);
        issue(ACT_SLEEP, 1, 0, 0, 32'd0);
        issue(ACT_SLEEP, 1, 0, 0, 32'hFFFF_FFFF);
        issue(ACT_SLEEP);
        issue(ACT_SCHEDULE);
        issue(ACT_WAIT, 1, 0, 2);
        issue(ACT_WAIT, 1, 0, 2);
        issue(ACT_POST, 1, 0, 0);
        issue(ACT_POST, 1, 0, 2);
        issue(ACT_TICK);
        drain();

        // Random phases under several count settings, with a calm stretch.
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int r = 0; r < 4; r++)
                write_count(r, (ph == 1) ? 16'hFFFF : (ph == 2) ? 16'd0 : 16'($urandom_range(3)));
            calm = (ph == 2);
            issue(ACT_KRESET);
            for (int n = 0; n < 200; n++)
                send_request(random_request());
            calm = 1'b0;
            drain();
        end

        $display("covered %0d requests over several initial semaphore settings, %0d results",
                 sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("task_scheduler_with_semaphores_test: clean");
        else
            $display("task_scheduler_with_semaphores_test: errors");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/scd_pkg.sv
hdl/scd_channels.sv
hdl/scd_cfg.sv
hdl/scd_task_mem.sv
hdl/scd_queue_mem.sv
hdl/task_scheduler_with_semaphores.sv
hdl/scd_checker.sv
dv/scd_scoreboard.sv
dv/task_scheduler_with_semaphores_test.sv
